[design/ffra_pkg.sv]
// Package: shared types and constants of the interval register allocator.
package ffra_pkg;

  localparam int unsigned FieldPosW = 16;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned RegW      = 4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PICK,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } ffra_state_t;

  typedef struct packed {
    logic [FieldPosW-1:0] range_start;
    logic [FieldPosW-1:0] range_end;
    logic                 reg_class;
    logic                 has_fixed;
    logic [RegW-1:0]      fixed_index;
    logic                 last_range;
  } ffra_in_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [RegW-1:0]  reg_index;
    logic             spilled;
    logic             overflowed;
    logic             last_result;
  } ffra_out_t;

endpackage

[design/ffra_if.sv]
// Interfaces: valid/ready channels for range items and result items.
interface ffra_in_if import ffra_pkg::*; ();
  logic     valid;
  logic     ready;
  ffra_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffra_out_if import ffra_pkg::*; ();
  logic      valid;
  logic      ready;
  ffra_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/first_fit_interval_register_allocator.sv]
// Top level: first-fit interval register allocator over a range table memory.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_ch.valid/ready    | start, end, class, fixed register, last
//  out_    | out | out_ch.valid/ready   | slot, register, spill, overflow, last
//
// Each accepted item is stored while the table has room; further items only set the
// overflow flag. On the last item each stored range i is allocated: a fixed range is
// emitted without a scan; a free range scans all n stored entries once per candidate
// register through the single read port, for up to pool candidates.
// Reset (synchronous, active low) empties the table; entries need no clearing.
// Input is held off while a batch allocates; a stalled result holds the engine.
module first_fit_interval_register_allocator
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_RANGES   = 64,
  parameter int unsigned GP_POOL_SIZE = 12,
  parameter int unsigned FP_POOL_SIZE = 16,
  parameter int unsigned POS_WIDTH    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ffra_in_if.sink    in_ch,
  ffra_out_if.source out_ch
);

  localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);

  typedef struct packed {
    logic [POS_WIDTH-1:0] lo;
    logic [POS_WIDTH-1:0] hi;
    logic                 cls;
    logic                 vld;
    logic [RegW-1:0]      idx;
  } entry_t;

  // range table memory
  entry_t mem [MAX_RANGES];
  entry_t rd_q;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;
  logic [IdxW-1:0]   rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  ffra_state_t        state_r, state_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CntW-1:0]    cur_r, cur_nxt;     // range under allocation
  logic [CntW-1:0]    scan_r, scan_nxt;   // address issued in scan
  logic               rvalid_r, rvalid_nxt;
  entry_t             cur_e_r, cur_e_nxt;
  logic [RegW:0]      cand_r, cand_nxt;
  logic               hit_r, hit_nxt;
  ffra_out_t          out_r, out_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [RegW:0]      pool;
  logic               overlap;

  assign pool = cur_e_r.cls ? (RegW+1)'(FP_POOL_SIZE) : (RegW+1)'(GP_POOL_SIZE);
  assign overlap = rd_q.vld && (rd_q.cls == cur_e_r.cls) && (rd_q.idx == cand_r[RegW-1:0])
                   && (rd_q.lo <= cur_e_r.hi) && (cur_e_r.lo <= rd_q.hi);

  assign in_ch.ready  = (state_r == ST_LOAD) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
      rvalid_r <= rvalid_nxt;
    end
    cur_r   <= cur_nxt;
    scan_r  <= scan_nxt;
    cur_e_r <= cur_e_nxt;
    cand_r  <= cand_nxt;
    hit_r   <= hit_nxt;
    out_r   <= out_nxt;
  end

  // sequence loads, scans and results
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    cur_nxt    = cur_r;
    scan_nxt   = scan_r;
    rvalid_nxt = 1'b0;
    cur_e_nxt  = cur_e_r;
    cand_nxt   = cand_r;
    hit_nxt    = hit_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    wr_en      = 1'b0;
    wr_addr    = cur_r[IdxW-1:0];
    wr_data    = cur_e_r;
    rd_addr    = cur_r[IdxW-1:0];

    case (state_r)
      ST_LOAD: begin
        wr_addr = count_r[IdxW-1:0];
        wr_data.lo  = POS_WIDTH'(in_ch.data.range_start);
        wr_data.hi  = POS_WIDTH'(in_ch.data.range_end);
        wr_data.cls = in_ch.data.reg_class;
        wr_data.vld = in_ch.data.has_fixed;
        wr_data.idx = in_ch.data.fixed_index;
        if (in_ch.valid && in_ch.ready) begin
          if (count_r < CntW'(MAX_RANGES)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.data.last_range) begin
            cur_nxt   = '0;
            state_nxt = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        // hold while the previous result waits; else fetch current range, or return to load after the last
        if (!ovalid_r || out_ch.ready) begin
          if (cur_r == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            rd_addr   = cur_r[IdxW-1:0];
            cand_nxt  = '0;
            scan_nxt  = '0;
            state_nxt = ST_DECIDE;
            hit_nxt   = 1'b1; // marks first fetch
          end
        end
      end
      ST_DECIDE: begin
        if (hit_r) begin
          // rd_q holds current entry
          cur_e_nxt = rd_q;
          hit_nxt   = 1'b0;
          if (rd_q.vld) begin
            state_nxt = ST_EMIT;
          end else if (cand_r >= ((rd_q.cls) ? (RegW+1)'(FP_POOL_SIZE)
                                              : (RegW+1)'(GP_POOL_SIZE))) begin
            state_nxt = ST_EMIT;
          end else begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end else if (!rvalid_r) begin
          // end of a candidate's scan
          if (!hit_r) begin
            state_nxt = ST_EMIT;
            cur_e_nxt.vld = 1'b1;
            cur_e_nxt.idx = cand_r[RegW-1:0];
            wr_en   = 1'b1;
            wr_data = cur_e_nxt;
          end
        end
      end
      ST_SCAN: begin
        // stream addresses; check each returned entry
        if (rvalid_r && overlap) begin
          hit_nxt = 1'b1;
        end
        if (scan_r < count_r) begin
          rd_addr    = scan_r[IdxW-1:0];
          rvalid_nxt = 1'b1;
          scan_nxt   = scan_r + 1'b1;
        end else if (!rvalid_r) begin
          if (hit_r || (rvalid_r && overlap)) begin
            cand_nxt = cand_r + 1'b1;
            hit_nxt  = 1'b0;
            scan_nxt = '0;
            if (cand_r + 1'b1 >= pool) begin
              state_nxt = ST_EMIT;
            end
          end else begin
            cur_e_nxt.vld = 1'b1;
            cur_e_nxt.idx = cand_r[RegW-1:0];
            wr_en     = 1'b1;
            wr_data   = cur_e_nxt;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // present result, advance to next range
        out_nxt.slot        = cur_r[SlotW-1:0];
        out_nxt.reg_index   = cur_e_r.vld ? cur_e_r.idx : '0;
        out_nxt.spilled     = !cur_e_r.vld;
        out_nxt.overflowed  = ovf_r;
        out_nxt.last_result = (cur_r + 1'b1 == count_r);
        ovalid_nxt = 1'b1;
        cur_nxt    = cur_r + 1'b1;
        state_nxt  = ST_PICK;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

[tb/ffra_checker.sv]
// Checker: predicts register allocation results and compares them with the output channel.
`timescale 1ns / 100ps
module ffra_checker
  import ffra_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  ffra_in_t     in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  ffra_out_t    out_data,
  output int unsigned  fail_count,
  output int unsigned  pending,
  output int unsigned  results_seen,
  output int unsigned  spills_seen
);

  localparam int unsigned TableDepth = 64;
  localparam int unsigned GpPool     = 12;
  localparam int unsigned FpPool     = 16;

  logic [15:0]     tab_start [TableDepth];
  logic [15:0]     tab_end   [TableDepth];
  logic            tab_class [TableDepth];
  logic            tab_held  [TableDepth];
  logic [RegW-1:0] tab_reg   [TableDepth];
  int unsigned     stored;
  logic            overflow_seen;
  ffra_out_t       expected_allocs [$];

  assign pending = expected_allocs.size();

  // True when no held register of this class and index overlaps [lo, hi]
  function automatic bit reg_free(int unsigned idx, logic cls, logic [15:0] lo,
                                  logic [15:0] hi);
    for (int unsigned k = 0; k < stored; k++) begin
      if (tab_held[k] && tab_class[k] == cls && tab_reg[k] == idx[RegW-1:0] &&
          tab_start[k] <= hi && lo <= tab_end[k])
        return 0;
    end
    return 1;
  endfunction

  // Store one range; on the final one allocate the whole batch
  task automatic load_range(ffra_in_t it);
    ffra_out_t   res;
    int unsigned pool;
    if (stored < TableDepth) begin
      tab_start[stored] = it.range_start;
      tab_end[stored]   = it.range_end;
      tab_class[stored] = it.reg_class;
      tab_held[stored]  = it.has_fixed;
      tab_reg[stored]   = it.has_fixed ? it.fixed_index : '0;
      stored++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (!it.last_range) return;
    for (int unsigned i = 0; i < stored; i++) begin
      res = '0;
      res.slot = i[SlotW-1:0];
      if (tab_held[i]) begin
        res.reg_index = tab_reg[i];
      end else begin
        pool = tab_class[i] ? FpPool : GpPool;
        res.spilled = 1'b1;
        for (int unsigned r = 0; r < pool; r++) begin
          if (reg_free(r, tab_class[i], tab_start[i], tab_end[i])) begin
            tab_held[i]   = 1'b1;
            tab_reg[i]    = r[RegW-1:0];
            res.reg_index = r[RegW-1:0];
            res.spilled   = 1'b0;
            break;
          end
        end
      end
      res.overflowed  = overflow_seen;
      res.last_result = (i + 1 == stored);
      expected_allocs = {expected_allocs, res};
    end
    stored        = 0;
    overflow_seen = 1'b0;
  endtask

  // Predict on accepted input items, compare accepted result items
  always @(posedge clk) begin
    ffra_out_t want;
    if (!rst_n) begin
      stored        = 0;
      overflow_seen = 1'b0;
      fail_count    <= 0;
      results_seen  <= 0;
      spills_seen   <= 0;
      expected_allocs.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_data.spilled) spills_seen <= spills_seen + 1;
        if (expected_allocs.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result item %p", out_data);
        end else begin
          want = expected_allocs.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("result differs: expected %p actual %p", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) load_range(in_data);
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top: drives range batches into the allocator and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
  import ffra_pkg::*;

  localparam int unsigned IdleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count, pending, results_seen, spills_seen;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;

  ffra_in_if  in_ch ();
  ffra_out_if out_ch ();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_fit_interval_register_allocator i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  ffra_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .spills_seen (spills_seen)
  );

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
  end

  // Stall the result side on a rotating pattern with quiet stretches
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_phase[9:8] == 2'd3) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: count cycles with no accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("first_fit_interval_register_allocator: mismatch");
      $finish;
    end
  end

  // Hold one item on the channel until accepted; bursts are split by gaps
  task automatic send_range(ffra_in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left   = $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  function automatic ffra_in_t make_range(logic [15:0] lo, logic [15:0] hi, logic cls,
                                          logic fixed, logic [3:0] idx, logic last);
    ffra_in_t it;
    it.range_start = lo;
    it.range_end   = hi;
    it.reg_class   = cls;
    it.has_fixed   = fixed;
    it.fixed_index = idx;
    it.last_range  = last;
    return it;
  endfunction

  // Random range, mostly narrow and clustered so registers collide
  function automatic ffra_in_t rand_range(logic last);
    logic [15:0] lo, hi;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      lo = 16'($urandom_range(0, 200));
      hi = lo + 16'($urandom_range(0, 60));
    end else if (mode < 8) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else begin
      lo = 16'($urandom_range(0, 30));
      hi = 16'hFFFF - 16'($urandom_range(0, 30));
    end
    return make_range(lo, hi, 1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0),
                      4'($urandom_range(0, 15)), last);
  endfunction

  // End the current burst, then wait until every expected result has come
  task automatic drain_results();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned batch_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, fixed in and out of pool, start after end
    send_range(make_range(16'h0000, 16'hFFFF, 1'b0, 1'b0, 4'h0, 1'b0));
    send_range(make_range(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 4'hF, 1'b0));
    send_range(make_range(16'h0010, 16'h0020, 1'b0, 1'b1, 4'hF, 1'b0));
    send_range(make_range(16'h0020, 16'h0010, 1'b0, 1'b0, 4'h0, 1'b0));
    send_range(make_range(16'h0000, 16'h0000, 1'b1, 1'b1, 4'h0, 1'b0));
    send_range(make_range(16'h0000, 16'hFFFF, 1'b1, 1'b0, 4'h5, 1'b0));
    send_range(make_range(16'hAAAA, 16'h5555, 1'b1, 1'b1, 4'hA, 1'b1));
    drain_results();
    // Single-range batch
    send_range(make_range(16'h5555, 16'hAAAA, 1'b1, 1'b0, 4'h0, 1'b1));
    // Exhaust the general pool with fully overlapping ranges, then spill
    for (int i = 0; i < 14; i++)
      send_range(make_range(16'h0100, 16'h0200, 1'b0, 1'b0, 4'h0, i == 13));
    // Overfill the table: 64 stored, 3 ignored, last one ignored too
    for (int i = 0; i < 67; i++)
      send_range(rand_range(i == 66));
    drain_results();

    // Random batches of mostly small size
    while (items_sent < 300) begin
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      for (int unsigned i = 0; i < batch_len; i++)
        send_range(rand_range(i + 1 == batch_len));
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("sent %0d range items, checked %0d allocations (%0d spills)",
             items_sent, results_seen, spills_seen);
    if (fail_count == 0 && pending == 0)
      $display("first_fit_interval_register_allocator: match");
    else
      $display("first_fit_interval_register_allocator: mismatch");
    $finish;
  end

endmodule
